/* hw/rtl/bebb_pkg.sv */
// ----------------------------------------------------------------------------
// bebb_pkg
// types and constants shared by the big-endian bit-field buffer
// ----------------------------------------------------------------------------
package bebb_pkg;

  localparam int STORE_BYTES_DEF = 1024;
  localparam logic [10:0] LEN_RESET = 11'd1024;

  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_SPAN  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic        operation;
    logic [12:0] bit_offset;
    logic [6:0]  bit_count;
    logic [63:0] write_value;
  } req_t;

  typedef struct packed {
    logic [63:0] read_value;
    logic [1:0]  status;
  } rsp_t;

  typedef struct packed {
    logic [5:0]  pos;
    logic [6:0]  count;
    logic [63:0] value;
  } field_ctl_t;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_ACCESS
  } state_t;

endpackage

/* hw/rtl/bebb_ram.sv */
// ----------------------------------------------------------------------------
// bebb_ram
// generic simple dual-port ram, one write port, registered read
// ----------------------------------------------------------------------------
module bebb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64,
  localparam int ABITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [ABITS-1:0] waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [ABITS-1:0] raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* hw/rtl/bebb_field.sv */
// ----------------------------------------------------------------------------
// bebb_field
// extracts and inserts a field in a 128-bit big-endian window of two words
// ----------------------------------------------------------------------------
module bebb_field (
  input  logic [127:0]            win,
  input  bebb_pkg::field_ctl_t    ctl,
  output logic [63:0]             rd,
  output logic [127:0]            merged
);
  import bebb_pkg::*;

  logic [63:0]  mask64;
  logic [127:0] mask128;
  logic [127:0] shifted;
  logic [7:0]   s;

  always_comb begin
    mask64  = (ctl.count == 7'd0) ? 64'd0 : ({64{1'b1}} >> (7'd64 - ctl.count));
    mask128 = {64'd0, mask64};
    s       = 8'd128 - {2'b00, ctl.pos} - {1'b0, ctl.count};
    shifted = win >> s;
    rd      = shifted[63:0] & mask64;
    merged  = (win & ~(mask128 << s)) | ({64'd0, ctl.value & mask64} << s);
  end

endmodule

/* hw/rtl/big_endian_bitfield_buffer_top.sv */
// ----------------------------------------------------------------------------
// big_endian_bitfield_buffer_top
// bit-addressed field read/write over a byte store, msb-first byte order
// ----------------------------------------------------------------------------
// usage:
//   an item (req) is taken at a clock edge with start high and busy low.
//   read: the field of bit_count bits at bit_offset comes back right-aligned.
//   write: only the field's bits are replaced by the low bits of write_value.
//   one result (rsp) per item, on rsp for one cycle with done high; the
//   receiver cannot stall it.
//   done and rsp are registered from the S_ACCESS state entered on acceptance.
//   busy is high for one cycle after acceptance, so a new item is not taken
//   until the current one is through; the store is two 64-bit banks (even/odd
//   words) read as the item is accepted and written back in S_ACCESS.
//   cfg_we/cfg_wdata write buffer_length, the number of bytes in use; write it
//   only while no item is in flight.
//   reset: the store is swept to zero, one row of both banks per cycle, with
//   busy high; buffer_length is 1024.
// ----------------------------------------------------------------------------
module big_endian_bitfield_buffer_top #(
  parameter int STORE_BYTES = bebb_pkg::STORE_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  output logic           busy,
  input  bebb_pkg::req_t req,
  output logic           done,
  output bebb_pkg::rsp_t rsp,
  input  logic           cfg_we,
  input  logic [10:0]    cfg_wdata
);
  import bebb_pkg::*;

  localparam int WORDS      = (STORE_BYTES + 7) / 8;
  localparam int BANK_DEPTH = (WORDS + 1) / 2;
  localparam int AW         = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  state_t state, state_next;
  logic [AW-1:0] clr_row, clr_row_next;
  logic [10:0]   buffer_length;

  // request side, combinational
  logic [6:0]  w;
  logic [7:0]  w_inc;
  logic [7:0]  span;
  logic [7:0]  reach;
  logic [19:0] used;
  logic [19:0] end_bit;
  logic [1:0]  status_in;
  logic [AW-1:0] row_even_in, row_odd_in;

  // registered request
  logic          op_q;
  logic          ok_q;
  logic          w_lsb_q;
  logic          touch_lo_q;
  logic [1:0]    status_q;
  logic [AW-1:0] row_even_q, row_odd_q;
  field_ctl_t    ctl_q;

  // memory ports
  logic          we_even, we_odd;
  logic [AW-1:0] waddr_even, waddr_odd;
  logic [63:0]   wdata_even, wdata_odd;
  logic [63:0]   rd_even, rd_odd;

  logic [127:0] win, merged;
  logic [63:0]  field_rd;
  logic         accept;

  always_comb begin
    w       = req.bit_offset[12:6];
    w_inc   = {1'b0, w} + 8'd1;
    row_even_in = AW'(w_inc[7:1]);
    row_odd_in  = AW'(w[6:1]);
    span    = {5'd0, req.bit_offset[2:0]} + {1'b0, req.bit_count};
    reach   = {2'b00, req.bit_offset[5:0]} + {1'b0, req.bit_count};
    used    = ({9'd0, buffer_length} > 20'(STORE_BYTES)) ? 20'(STORE_BYTES)
                                                         : {9'd0, buffer_length};
    end_bit = {7'd0, req.bit_offset} + {13'd0, req.bit_count};
    if (span > 8'd64) begin
      status_in = ST_SPAN;
    end else if (end_bit > (used << 3)) begin
      status_in = ST_RANGE;
    end else begin
      status_in = ST_DONE;
    end
  end

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLEAR;
      clr_row       <= '0;
      buffer_length <= LEN_RESET;
      done          <= 1'b0;
    end else begin
      state   <= state_next;
      clr_row <= clr_row_next;
      done    <= (state == S_ACCESS);
      if (cfg_we) begin
        buffer_length <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q       <= req.operation;
      ok_q       <= (status_in == ST_DONE) && (req.bit_count != 7'd0);
      w_lsb_q    <= w[0];
      touch_lo_q <= reach > 8'd64;
      status_q   <= status_in;
      row_even_q <= row_even_in;
      row_odd_q  <= row_odd_in;
      ctl_q      <= '{pos: req.bit_offset[5:0], count: req.bit_count,
                      value: req.write_value};
    end
    if (state == S_ACCESS) begin
      rsp.status     <= status_q;
      rsp.read_value <= (ok_q && op_q == OP_READ) ? field_rd : 64'd0;
    end
  end

  assign win = w_lsb_q ? {rd_odd, rd_even} : {rd_even, rd_odd};

  bebb_field u_field (
    .win    (win),
    .ctl    (ctl_q),
    .rd     (field_rd),
    .merged (merged)
  );

  always_comb begin
    state_next   = state;
    clr_row_next = clr_row;
    busy         = 1'b1;
    we_even      = 1'b0;
    we_odd       = 1'b0;
    waddr_even   = row_even_q;
    waddr_odd    = row_odd_q;
    wdata_even   = w_lsb_q ? merged[63:0] : merged[127:64];
    wdata_odd    = w_lsb_q ? merged[127:64] : merged[63:0];
    case (state)
      S_CLEAR: begin
        we_even    = 1'b1;
        we_odd     = 1'b1;
        waddr_even = clr_row;
        waddr_odd  = clr_row;
        wdata_even = 64'd0;
        wdata_odd  = 64'd0;
        if (clr_row == AW'(BANK_DEPTH - 1)) begin
          state_next = S_IDLE;
        end else begin
          clr_row_next = clr_row + AW'(1);
        end
      end
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          state_next = S_ACCESS;
        end
      end
      S_ACCESS: begin
        we_even    = ok_q && (op_q == OP_WRITE) && (w_lsb_q ? touch_lo_q : 1'b1);
        we_odd     = ok_q && (op_q == OP_WRITE) && (w_lsb_q ? 1'b1 : touch_lo_q);
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  bebb_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (waddr_even),
    .wdata (wdata_even),
    .raddr (row_even_in),
    .rdata (rd_even)
  );

  bebb_ram #(.WIDTH(64), .DEPTH(BANK_DEPTH)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (waddr_odd),
    .wdata (wdata_odd),
    .raddr (row_odd_in),
    .rdata (rd_odd)
  );

endmodule
